FILE: hw/rtl/fcsa_pkg.sv
package fcsa_pkg;

   localparam int CHANNELS        = 4;
   localparam int VALUE_WIDTH     = 16;
   localparam int DELAY_WIDTH     = 16;
   localparam int SAMPLE_WIDTH    = 16;
   localparam int SETUP_WIDTH     = 2 * VALUE_WIDTH + DELAY_WIDTH + 3;
   localparam int CSR_INDEX_WIDTH = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CMP_WIDTH       =
      ((SAMPLE_WIDTH > VALUE_WIDTH) ? SAMPLE_WIDTH : VALUE_WIDTH) + 2;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_ACK    = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                     flash_phase;
   } req_type;

   typedef struct packed {
      logic [CHANNELS-1:0] relay_bits;
      logic [CHANNELS-1:0] led_bits;
      logic [CHANNELS-1:0] alarm_bits;
      logic                buzzer;
   } rsp_type;

   typedef struct packed {
      logic                          latch;
      logic                          high;
      logic                          enable;
      logic [DELAY_WIDTH-1:0]        delay;
      logic [VALUE_WIDTH-1:0]        hysteresis;
      logic signed [VALUE_WIDTH-1:0] setpoint;
   } setup_type;

   typedef struct packed {
      logic relay;
      logic led;
      logic alarm;
      logic buzz;
   } chan_status_type;

endpackage

FILE: hw/rtl/fcsa_channel.sv
module fcsa_channel
   import fcsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  req_type         req,
   input  setup_type       setup,
   output chan_status_type status
);

   logic                   active_ff, active_in;
   logic                   acked_ff, acked_in;
   logic                   running_ff, running_in;
   logic                   elapsed_ff, elapsed_in;
   logic [DELAY_WIDTH-1:0] count_ff, count_in;
   logic                   request_ff, request_in;
   logic                   silenced_ff, silenced_in;

   logic signed [CMP_WIDTH-1:0] sample_ext;
   logic signed [CMP_WIDTH-1:0] setpoint_ext;
   logic signed [CMP_WIDTH-1:0] hyst_ext;
   logic signed [CMP_WIDTH-1:0] trip_level;
   logic                        trip;
   logic                        clear;
   logic [DELAY_WIDTH:0]        count_next;

   always_comb begin
      sample_ext   = CMP_WIDTH'(req.sample);
      setpoint_ext = CMP_WIDTH'(setup.setpoint);
      hyst_ext     = $signed({{(CMP_WIDTH-VALUE_WIDTH){1'b0}}, setup.hysteresis});
      if (setup.high) begin
         trip_level = setpoint_ext + hyst_ext;
         trip       = (sample_ext >= trip_level) && !acked_ff;
         clear      = sample_ext < setpoint_ext;
      end else begin
         trip_level = setpoint_ext - hyst_ext;
         trip       = (sample_ext <= trip_level) && !acked_ff;
         clear      = sample_ext > setpoint_ext;
      end
      count_next = {1'b0, count_ff} + {{DELAY_WIDTH{1'b0}}, 1'b1};
   end

   always_comb begin
      active_in   = active_ff;
      acked_in    = acked_ff;
      running_in  = running_ff;
      elapsed_in  = elapsed_ff;
      count_in    = count_ff;
      request_in  = request_ff;
      silenced_in = silenced_ff;
      case (req.cmd)
         CMD_SAMPLE: begin
            if (setup.enable) begin
               if (trip) begin
                  running_in = 1'b1;
                  if (elapsed_ff) begin
                     if (!silenced_ff) begin
                        request_in = 1'b1;
                     end
                     active_in  = 1'b1;
                     running_in = 1'b0;
                  end
               end else begin
                  running_in = 1'b0;
                  count_in   = '0;
                  if (clear && (!setup.latch || acked_ff)) begin
                     if (silenced_ff) begin
                        request_in  = 1'b0;
                        silenced_in = 1'b0;
                     end
                     elapsed_in = 1'b0;
                     active_in  = 1'b0;
                     acked_in   = 1'b0;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (setup.enable && running_ff) begin
               if (count_next > {1'b0, setup.delay}) begin
                  count_in   = '0;
                  elapsed_in = 1'b1;
               end else begin
                  count_in = count_next[DELAY_WIDTH-1:0];
               end
            end
         end
         CMD_ACK: begin
            if (active_ff && setup.latch) begin
               acked_in = 1'b1;
            end
            if (request_ff) begin
               silenced_in = 1'b1;
               request_in  = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         acked_ff    <= 1'b0;
         running_ff  <= 1'b0;
         elapsed_ff  <= 1'b0;
         count_ff    <= '0;
         request_ff  <= 1'b0;
         silenced_ff <= 1'b0;
      end else if (step) begin
         active_ff   <= active_in;
         acked_ff    <= acked_in;
         running_ff  <= running_in;
         elapsed_ff  <= elapsed_in;
         count_ff    <= count_in;
         request_ff  <= request_in;
         silenced_ff <= silenced_in;
      end
   end

   always_comb begin
      status.alarm = setup.enable && active_in;
      status.relay = setup.enable && active_in && !acked_in;
      status.led   = setup.enable && active_in && (acked_in || req.flash_phase);
      status.buzz  = setup.enable && request_in && !silenced_in;
   end

endmodule

FILE: hw/rtl/four_channel_setpoint_alarm.sv
// The result of an item is registered when it is accepted and presented in the next cycle.
// Throughput: one item per cycle; the per-channel state update and the result
// register form a single stage, and a new item is taken when the result register
// is empty or its item leaves in the same cycle.
// Reset (synchronous, active high) clears all channel state, the setup
// registers and the result valid flag.
module four_channel_setpoint_alarm
   import fcsa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_item,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [SETUP_WIDTH-1:0]     csr_wdata
);

   setup_type       setup_ff [CHANNELS];
   chan_status_type status [CHANNELS];
   logic            rsp_valid_ff;
   rsp_type         rsp_item_ff, rsp_item_in;
   logic            step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            setup_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (csr_index == CSR_INDEX_WIDTH'(i)) begin
               setup_ff[i] <= setup_type'(csr_wdata);
            end
         end
      end
   end

   for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      fcsa_channel u_channel (
         .clock  (clock),
         .reset  (reset),
         .step   (step),
         .req    (req_item),
         .setup  (setup_ff[g]),
         .status (status[g])
      );
   end

   always_comb begin
      rsp_item_in.buzzer = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         rsp_item_in.relay_bits[i] = status[i].relay;
         rsp_item_in.led_bits[i]   = status[i].led;
         rsp_item_in.alarm_bits[i] = status[i].alarm;
         rsp_item_in.buzzer        = rsp_item_in.buzzer | status[i].buzz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_relay_needs_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.relay_bits & ~rsp_item.alarm_bits) == '0))
      else $error("relay energized without an active alarm");

   a_led_needs_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.led_bits & ~rsp_item.alarm_bits) == '0))
      else $error("led lit without an active alarm");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted item produced no result");

   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
